@@ rtl/dps_pkg.sv @@
// shared types, widths and constants for the depth pyramid subsample core
// no dependencies
package dps_pkg;

  localparam int DPS_MAX_WIDTH = 1024;
  localparam int DEPTH_W       = 16;
  localparam int CFG_WIDTH_W   = 11;
  localparam int CFG_HEIGHT_W  = 13;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;
  localparam int NWIN          = 9;
  localparam int CNT_W         = 4;
  localparam int SUM_W         = DEPTH_W + CNT_W;
  localparam int RECIP_SHIFT   = SUM_W + 4;
  localparam int RECIP_W       = RECIP_SHIFT + 1;
  localparam int PROD_W        = SUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd2;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [DEPTH_W-1:0]      THRESH_RESET = 16'd99;

  typedef struct packed {
    logic take;
    logic look;
    logic win;
    logic sum;
    logic mul;
    logic load;
  } dps_cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } dps_stat_t;

  // floor(2^RECIP_SHIFT / count), zero for an empty window
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] c);
    logic [RECIP_W-1:0] r;
    case (c)
      4'd1:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1);
      4'd2:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd2);
      4'd3:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd3);
      4'd4:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd4);
      4'd5:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd5);
      4'd6:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd6);
      4'd7:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd7);
      4'd8:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd8);
      4'd9:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd9);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/dps_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module dps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dps_ctrl.sv @@
// sequencing state machine for the depth pyramid subsample core
// depends on dps_pkg
module dps_ctrl import dps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dps_stat_t st,
  output dps_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WIN,
    S_SUM,
    S_MUL,
    S_FIX
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_WIN;
      end
      S_WIN: begin
        cmd.win   = 1'b1;
        state_nxt = st.emit ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.load = st.out_free;
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/dps_datapath.sv @@
// position tracking, config registers, 3x3 window, average and output register
// depends on dps_pkg; line stores live outside as dps_ram instances
module dps_datapath import dps_pkg::*; #(
  parameter int MAX_WIDTH = DPS_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dps_cmd_t                     cmd,
  output dps_stat_t                    st,
  input  logic [DEPTH_W-1:0]           in_depth_mm,
  input  logic                         in_frame_start,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_addr,
  output logic                         ram_re,
  output logic                         even_we,
  output logic                         odd_we,
  output logic [DEPTH_W-1:0]           ram_wdata,
  input  logic [DEPTH_W-1:0]           even_rdata,
  input  logic [DEPTH_W-1:0]           odd_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [DEPTH_W-1:0]           out_depth,
  output logic                         out_row_last,
  output logic                         out_frame_last
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WCW  = $clog2(MAX_WIDTH + 1);
  localparam int WEXT = (CFG_WIDTH_W > WCW) ? CFG_WIDTH_W : WCW;

  // config registers
  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;
  logic [DEPTH_W-1:0]      thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      thr_r    <= THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_W-1:0];
        CFG_IDX_HEIGHT: height_r <= cfg_data[CFG_HEIGHT_W-1:0];
        CFG_IDX_THRESH: thr_r    <= cfg_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped image size
  logic [WEXT-1:0]         width_ext;
  logic [WCW-1:0]          w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;

  always_comb begin
    width_ext = WEXT'(width_r);
    if (width_ext < WEXT'(2)) begin
      w_eff = WCW'(2);
    end else if (width_ext > WEXT'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(width_ext);
    end
    if (height_r < CFG_HEIGHT_W'(2)) begin
      h_eff = CFG_HEIGHT_W'(2);
    end else if (height_r > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = CFG_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // raster position
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    x_r, x_nxt;
  logic [ROW_W-1:0] y_r, y_nxt;
  logic [DEPTH_W-1:0] pix_r;
  logic [CW-1:0]    c0;
  logic [ROW_W:0]   r0;
  logic [WCW-1:0]   xn;
  logic [ROW_W:0]   yn;

  always_comb begin
    c0 = in_frame_start ? '0 : col_r;
    r0 = in_frame_start ? '0 : {1'b0, row_r};
    if (WCW'(c0) >= w_eff) begin
      c0 = '0;
      r0 = r0 + 1'b1;
    end
    if (r0 >= h_eff) begin
      r0 = '0;
    end
    x_nxt = c0;
    y_nxt = r0[ROW_W-1:0];

    xn      = WCW'(x_r) + 1'b1;
    yn      = {1'b0, y_r};
    col_nxt = xn[CW-1:0];
    row_nxt = y_r;
    if (xn >= w_eff) begin
      col_nxt = '0;
      yn      = yn + 1'b1;
      if (yn >= h_eff) begin
        yn = '0;
      end
      row_nxt = yn[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.look) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      pix_r <= in_depth_mm;
    end
  end

  // line store access
  assign ram_addr  = x_r;
  assign ram_re    = cmd.look;
  assign ram_wdata = pix_r;
  assign even_we   = cmd.look && !y_r[0];
  assign odd_we    = cmd.look && y_r[0];

  // window history along the current odd row
  logic [DEPTH_W-1:0] tail0_r, tail1_r;
  logic [DEPTH_W-1:0] ev_a_r, ev_b_r, pp_a_r, pp_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail0_r <= '0;
      tail1_r <= '0;
    end else if (cmd.win && y_r[0]) begin
      tail0_r <= tail1_r;
      tail1_r <= odd_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win && y_r[0]) begin
      ev_b_r <= ev_a_r;
      ev_a_r <= even_rdata;
      pp_b_r <= pp_a_r;
      pp_a_r <= pix_r;
    end
  end

  // neighbour test
  logic               has_top, has_left;
  logic [DEPTH_W-1:0] centre;
  logic [DEPTH_W-1:0] win_v [NWIN];
  logic [NWIN-1:0]    win_en;
  logic [DEPTH_W-1:0] win_d [NWIN];
  logic [DEPTH_W-1:0] val_nxt [NWIN];
  logic [NWIN-1:0]    pass_nxt;
  logic               rl_nxt, fl_nxt;

  assign has_top  = |y_r[ROW_W-1:1];
  assign has_left = |x_r[CW-1:1];
  assign centre   = ev_a_r;

  always_comb begin
    win_v[0] = tail0_r;
    win_v[1] = tail1_r;
    win_v[2] = odd_rdata;
    win_v[3] = ev_b_r;
    win_v[4] = centre;
    win_v[5] = even_rdata;
    win_v[6] = pp_b_r;
    win_v[7] = pp_a_r;
    win_v[8] = pix_r;
    win_en   = {1'b1, 1'b1, has_left, 1'b1, 1'b1, has_left,
                has_top, has_top, has_top && has_left};
    for (int i = 0; i < NWIN; i++) begin
      win_d[i]    = (win_v[i] > centre) ? win_v[i] - centre : centre - win_v[i];
      pass_nxt[i] = win_en[i] && (win_v[i] != '0) && (centre != '0) && (win_d[i] <= thr_r);
      val_nxt[i]  = pass_nxt[i] ? win_v[i] : '0;
    end
    rl_nxt = ({1'b0, WCW'(x_r)} + (WCW+1)'(2)) >= {1'b0, w_eff};
    fl_nxt = rl_nxt && (({2'b0, y_r} + (ROW_W+2)'(2)) >= (ROW_W+2)'(h_eff));
  end

  logic [DEPTH_W-1:0] val_r [NWIN];
  logic [NWIN-1:0]    pass_r;
  logic               cz_r, rl_r, fl_r;

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      val_r  <= val_nxt;
      pass_r <= pass_nxt;
      cz_r   <= (centre == '0);
      rl_r   <= rl_nxt;
      fl_r   <= fl_nxt;
    end
  end

  assign st.emit = y_r[0] && x_r[0];

  // sum and count
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NWIN; i++) begin
      sum_nxt = sum_nxt + SUM_W'(val_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r <= sum_nxt;
      cnt_r <= CNT_W'($countones(pass_r));
    end
  end

  // reciprocal multiply then one-step quotient fix
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(recip(cnt_r));
    end
  end

  logic [SUM_W-1:0]       q_est;
  logic [SUM_W+CNT_W-1:0] qc_w;
  logic [SUM_W-1:0]       rem_w;
  logic [SUM_W-1:0]       q_fix;
  logic [DEPTH_W-1:0]     res;

  always_comb begin
    q_est = prod_r[RECIP_SHIFT +: SUM_W];
    qc_w  = (SUM_W+CNT_W)'(q_est) * (SUM_W+CNT_W)'(cnt_r);
    rem_w = sum_r - qc_w[SUM_W-1:0];
    q_fix = (rem_w >= SUM_W'(cnt_r)) ? q_est + 1'b1 : q_est;
    res   = (cnt_r == '0) ? '0 : q_fix[DEPTH_W-1:0];
  end

  // output register
  logic               out_valid_r;
  logic [DEPTH_W-1:0] out_depth_r;
  logic               out_row_last_r, out_frame_last_r;

  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_depth_r      <= res;
      out_row_last_r   <= rl_r;
      out_frame_last_r <= fl_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_depth      = out_depth_r;
  assign out_row_last   = out_row_last_r;
  assign out_frame_last = out_frame_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> cnt_r <= CNT_W'(NWIN))
    else $error("window count above nine");

  a_quot_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && cnt_r != '0) |->
      (qc_w <= (SUM_W+CNT_W)'(sum_r)) && ((SUM_W+1)'(rem_w) < (SUM_W+1)'({cnt_r, 1'b0})))
    else $error("reciprocal quotient off by more than one");

  a_bad_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sum && cz_r) |-> pass_r == '0)
    else $error("neighbour accepted around invalid centre");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ rtl/depth_pyramid_subsample_core.sv @@
// top level of the depth pyramid 2x subsampler: controller, datapath, two line stores
// depends on dps_pkg, dps_ram, dps_ctrl, dps_datapath
//
// Takes a raster stream of 16-bit depth pixels (0 = invalid) and emits one averaged
// pixel per 2x2 block, at the beat of input pixel (odd row, odd column), from a
// thresholded 3x3 window around the even/even centre. Each input beat goes through
// accept, line store access and window test when it closes no block, and also through
// sum, reciprocal multiply and quotient fix when it does; the line store access step
// is there for the registered read port of the two MAX_WIDTH x 16 line stores. A new
// beat is accepted while a result waits on out_ready; only the final step of the next
// result waits for it. cfg_ready is always high; write config only while idle.
// Entries of the odd line store are read for the top of the window before the
// frame's second row has refreshed them only when the top neighbours are excluded, so
// no clearing pass is needed after reset.
module depth_pyramid_subsample_core import dps_pkg::*; #(
  parameter int MAX_WIDTH = DPS_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DEPTH_W-1:0]    in_depth_mm,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DEPTH_W-1:0]    out_depth,
  output logic                  out_row_last,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  dps_cmd_t           cmd;
  dps_stat_t          st;
  logic [CW-1:0]      ram_addr;
  logic               ram_re, even_we, odd_we;
  logic [DEPTH_W-1:0] ram_wdata, even_rdata, odd_rdata;

  dps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  dps_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_depth_mm    (in_depth_mm),
    .in_frame_start (in_frame_start),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .ram_addr       (ram_addr),
    .ram_re         (ram_re),
    .even_we        (even_we),
    .odd_we         (odd_we),
    .ram_wdata      (ram_wdata),
    .even_rdata     (even_rdata),
    .odd_rdata      (odd_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_depth      (out_depth),
    .out_row_last   (out_row_last),
    .out_frame_last (out_frame_last)
  );

  dps_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_WIDTH)
  ) u_even_ram (
    .clk   (clk),
    .we    (even_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (even_rdata)
  );

  dps_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_WIDTH)
  ) u_odd_ram (
    .clk   (clk),
    .we    (odd_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (odd_rdata)
  );

endmodule
